// ----- sv/lgrc_pkg.sv -----
// Shared types and constants for the guest register cache.
`timescale 1ns / 1ps
package lgrc_pkg;

  localparam int GUEST_REGS = 16;
  localparam int HOST_REGS  = 16;
  localparam int GW         = 4;
  localparam int HW         = 4;
  localparam int MAX_ACTIONS = 8;
  localparam logic [4:0] POOL_SIZE_RESET = 5'd10;
  localparam logic [4:0] NO_HOST  = 5'd16;
  localparam logic [4:0] NO_GUEST = 5'd16;

  typedef enum logic [3:0] {
    OP_MAP_READ      = 4'd0,
    OP_MAP_WRITE     = 4'd1,
    OP_COPY_TEMP     = 4'd2,
    OP_ASSIGN        = 4'd3,
    OP_SET_DIRTY     = 4'd4,
    OP_TOUCH         = 4'd5,
    OP_REMOVE        = 4'd6,
    OP_STORE_ONE     = 4'd7,
    OP_STORE_ALL     = 4'd8,
    OP_FLUSH         = 4'd9,
    OP_ALLOC_TEMP    = 4'd10,
    OP_FREE_HOST     = 4'd11,
    OP_CLEAR_CHANGED = 4'd12,
    OP_STATUS        = 4'd13
  } lgrc_op_t;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_STORE = 2'd1,
    KIND_MOVE  = 2'd2,
    KIND_RESP  = 2'd3
  } lgrc_kind_t;

  typedef struct packed {
    logic       latch_req;
    logic       take;
    logic       set_tgt_g;
    logic       set_tgt_victim;
    logic       set_tgt_last;
    logic       set_tgt_cnt;
    logic       cnt_inc;
    logic       list_remove;
    logic       list_touch;
    logic       list_insert;
    logic       list_clear;
    logic       disc_a;
    logic       release_host;
    logic       assign_a;
    logic       rel_from_hr;
    logic       map_g_h;
    logic       set_dirty_g;
    logic       ret_from_map;
    logic       ret_from_h;
    logic       ret_from_hr;
    logic       exh_set;
    logic       clear_changed;
    logic       emit;
    lgrc_kind_t emit_kind;
  } lgrc_cmd_t;

  typedef struct packed {
    lgrc_op_t op;
    logic     out_free;
    logic     g_mapped;
    logic     tgt_dirty;
    logic     pool_free;
    logic     list_empty;
    logic     last_valid;
    logic     g_in_list;
    logic     tgt_in_list;
    logic     cnt_last;
  } lgrc_sts_t;

endpackage

// ----- sv/lgrc_datapath.sv -----
// Datapath: register map, recency list, pool bits and the output register.
`timescale 1ns / 1ps
module lgrc_datapath import lgrc_pkg::*; #(
  parameter int LRU_SLOTS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [3:0]      in_op,
  input  logic [GW-1:0]   in_guest_reg,
  input  logic [HW-1:0]   in_host_reg,
  input  logic            cfg_wr_en,
  input  logic [4:0]      cfg_wr_data,
  input  lgrc_cmd_t       cmd,
  output lgrc_sts_t       sts,
  input  logic            out_tready,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [GW-1:0]   out_action_guest,
  output logic [HW-1:0]   out_result_host,
  output logic [HW-1:0]   out_source_host,
  output logic            out_exhausted,
  output logic [4:0]      out_query_host,
  output logic            out_query_dirty,
  output logic            out_host_is_mapped,
  output logic [15:0]     out_temp_mask,
  output logic [15:0]     out_new_alloc_mask
);

  logic [4:0]            map_r   [GUEST_REGS];
  logic [4:0]            map_nxt [GUEST_REGS];
  logic [GUEST_REGS-1:0] dirty_r, dirty_nxt;
  logic [4:0]            slot_r   [LRU_SLOTS];
  logic [4:0]            slot_nxt [LRU_SLOTS];
  logic [HOST_REGS-1:0]  pool_r, pool_nxt;
  logic [15:0]           changed_r, changed_nxt;
  logic [4:0]            pool_size_r, pool_size_nxt;
  logic [3:0]            op_r, op_nxt;
  logic [GW-1:0]         g_r, g_nxt, tgt_r, tgt_nxt, cnt_r, cnt_nxt;
  logic [HW-1:0]         hr_r, hr_nxt, h_r, h_nxt, ret_r, ret_nxt;
  logic [4:0]            rel_r, rel_nxt;
  logic                  exh_r, exh_nxt;
  logic [3:0]            acts_r, acts_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [1:0]            out_kind_r;
  logic [GW-1:0]         out_ag_r;
  logic [HW-1:0]         out_rh_r, out_sh_r;
  logic                  out_exh_r, out_qd_r, out_him_r;
  logic [4:0]            out_qh_r;
  logic [15:0]           out_tm_r, out_cm_r;

  logic [HOST_REGS-1:0]  mapped_vec, lim_mask, free_vec;
  logic [HW-1:0]         take_idx;
  logic [LRU_SLOTS-1:0]  hit_g, hit_t, ge_g, le_t;
  logic [5*(LRU_SLOTS+1)-1:0] flat_up, flat_dn;
  logic [GW-1:0]         victim;
  logic [15:0]           tmask;
  logic                  out_free, out_load, is_action;

  // Reverse lookup: which host registers some guest maps to.
  always_comb begin
    for (int h = 0; h < HOST_REGS; h++) begin
      mapped_vec[h] = 1'b0;
      for (int i = 0; i < GUEST_REGS; i++) begin
        if (map_r[i] == 5'(h)) mapped_vec[h] = 1'b1;
      end
      lim_mask[h] = pool_size_r > 5'(h);
    end
  end

  assign free_vec = ~pool_r & lim_mask;
  assign tmask    = 16'(pool_r & lim_mask & ~mapped_vec);

  always_comb begin
    take_idx = '0;
    for (int h = HOST_REGS - 1; h >= 0; h--) begin
      if (free_vec[h]) take_idx = HW'(h);
    end
  end

  // Recency list helpers. The list is always packed toward slot 0.
  always_comb begin
    victim = '0;
    for (int i = 0; i < LRU_SLOTS; i++) begin
      hit_g[i] = slot_r[i] == {1'b0, g_r};
      hit_t[i] = slot_r[i] == {1'b0, tgt_r};
      if (!slot_r[i][4]) victim = slot_r[i][GW-1:0];
      flat_up[5*i +: 5]     = slot_r[i];
      flat_dn[5*(i+1) +: 5] = slot_r[i];
    end
    flat_up[5*LRU_SLOTS +: 5] = NO_GUEST;
    flat_dn[4:0]              = {1'b0, g_r};
    ge_g[LRU_SLOTS-1] = hit_g[LRU_SLOTS-1];
    for (int i = LRU_SLOTS - 2; i >= 0; i--) ge_g[i] = ge_g[i+1] | hit_g[i];
    le_t[0] = hit_t[0];
    for (int i = 1; i < LRU_SLOTS; i++) le_t[i] = le_t[i-1] | hit_t[i];
  end

  assign out_free  = !out_valid_r || out_tready;
  assign is_action = cmd.emit_kind != KIND_RESP;
  assign out_load  = cmd.emit && (!is_action || acts_r < 4'(MAX_ACTIONS));

  always_comb begin
    sts.op          = lgrc_op_t'(op_r);
    sts.out_free    = out_free;
    sts.g_mapped    = !map_r[g_r][4];
    sts.tgt_dirty   = dirty_r[tgt_r];
    sts.pool_free   = |free_vec;
    sts.list_empty  = slot_r[0][4];
    sts.last_valid  = !slot_r[LRU_SLOTS-1][4];
    sts.g_in_list   = |hit_g;
    sts.tgt_in_list = |hit_t;
    sts.cnt_last    = cnt_r == GW'(GUEST_REGS - 1);
  end

  always_comb begin
    map_nxt       = map_r;
    dirty_nxt     = dirty_r;
    slot_nxt      = slot_r;
    pool_nxt      = pool_r;
    changed_nxt   = changed_r;
    pool_size_nxt = cfg_wr_en ? cfg_wr_data : pool_size_r;
    op_nxt        = op_r;
    g_nxt         = g_r;
    hr_nxt        = hr_r;
    tgt_nxt       = tgt_r;
    cnt_nxt       = cnt_r;
    h_nxt         = h_r;
    rel_nxt       = rel_r;
    ret_nxt       = ret_r;
    exh_nxt       = exh_r;
    acts_nxt      = (out_load && is_action) ? acts_r + 4'd1 : acts_r;

    if (cmd.latch_req) begin
      op_nxt   = in_op;
      g_nxt    = in_guest_reg;
      hr_nxt   = in_host_reg;
      ret_nxt  = '0;
      exh_nxt  = 1'b0;
      acts_nxt = '0;
      cnt_nxt  = '0;
    end
    if (cmd.set_tgt_g)      tgt_nxt = g_r;
    if (cmd.set_tgt_victim) tgt_nxt = victim;
    if (cmd.set_tgt_last)   tgt_nxt = slot_r[LRU_SLOTS-1][GW-1:0];
    if (cmd.set_tgt_cnt)    tgt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
      tgt_nxt = cnt_r + 1'b1;
    end
    if (cmd.take) begin
      pool_nxt[take_idx]    = 1'b1;
      changed_nxt[take_idx] = 1'b1;
      h_nxt                 = take_idx;
    end
    for (int i = 0; i < LRU_SLOTS; i++) begin
      if (cmd.list_touch && ge_g[i]) slot_nxt[i] = flat_dn[5*i +: 5];
      if (cmd.list_remove && le_t[i]) slot_nxt[i] = flat_up[5*(i+1) +: 5];
      if (cmd.list_insert) slot_nxt[i] = flat_dn[5*i +: 5];
      if (cmd.list_clear) slot_nxt[i] = NO_GUEST;
    end
    if (cmd.disc_a) begin
      dirty_nxt[tgt_r] = 1'b0;
      map_nxt[tgt_r]   = NO_HOST;
      rel_nxt          = map_r[tgt_r];
    end
    // A host is returned to the pool only if no guest still maps to it.
    if (cmd.release_host && !rel_r[4] && !mapped_vec[rel_r[HW-1:0]]) begin
      pool_nxt[rel_r[HW-1:0]] = 1'b0;
    end
    if (cmd.assign_a) begin
      rel_nxt        = map_r[g_r];
      map_nxt[g_r]   = {1'b0, hr_r};
      dirty_nxt[g_r] = 1'b1;
    end
    if (cmd.rel_from_hr)   rel_nxt = {1'b0, hr_r};
    if (cmd.map_g_h)       map_nxt[g_r] = {1'b0, h_r};
    if (cmd.set_dirty_g)   dirty_nxt[g_r] = 1'b1;
    if (cmd.ret_from_map)  ret_nxt = map_r[g_r][HW-1:0];
    if (cmd.ret_from_h)    ret_nxt = h_r;
    if (cmd.ret_from_hr)   ret_nxt = hr_r;
    if (cmd.exh_set)       exh_nxt = 1'b1;
    if (cmd.clear_changed) changed_nxt = '0;

    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GUEST_REGS; i++) map_r[i] <= NO_HOST;
      for (int i = 0; i < LRU_SLOTS; i++) slot_r[i] <= NO_GUEST;
      dirty_r     <= '0;
      pool_r      <= '0;
      changed_r   <= '0;
      pool_size_r <= POOL_SIZE_RESET;
      out_valid_r <= 1'b0;
      acts_r      <= '0;
      exh_r       <= 1'b0;
    end else begin
      map_r       <= map_nxt;
      slot_r      <= slot_nxt;
      dirty_r     <= dirty_nxt;
      pool_r      <= pool_nxt;
      changed_r   <= changed_nxt;
      pool_size_r <= pool_size_nxt;
      out_valid_r <= out_valid_nxt;
      acts_r      <= acts_nxt;
      exh_r       <= exh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    g_r   <= g_nxt;
    hr_r  <= hr_nxt;
    tgt_r <= tgt_nxt;
    cnt_r <= cnt_nxt;
    h_r   <= h_nxt;
    rel_r <= rel_nxt;
    ret_r <= ret_nxt;
    if (out_load) begin
      out_kind_r <= cmd.emit_kind;
      out_ag_r   <= '0;
      out_rh_r   <= '0;
      out_sh_r   <= '0;
      out_exh_r  <= 1'b0;
      out_qh_r   <= '0;
      out_qd_r   <= 1'b0;
      out_him_r  <= 1'b0;
      out_tm_r   <= '0;
      out_cm_r   <= '0;
      case (cmd.emit_kind)
        KIND_LOAD: begin
          out_ag_r <= g_r;
          out_rh_r <= h_r;
        end
        KIND_STORE: begin
          out_ag_r <= tgt_r;
          out_sh_r <= map_r[tgt_r][HW-1:0];
        end
        KIND_MOVE: begin
          out_rh_r <= h_r;
          out_sh_r <= map_r[g_r][HW-1:0];
        end
        default: begin
          out_rh_r  <= ret_r;
          out_exh_r <= exh_r;
          out_qh_r  <= map_r[g_r];
          out_qd_r  <= dirty_r[g_r];
          out_him_r <= mapped_vec[hr_r];
          out_tm_r  <= tmask;
          out_cm_r  <= changed_r;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_action_guest   = out_ag_r;
  assign out_result_host    = out_rh_r;
  assign out_source_host    = out_sh_r;
  assign out_exhausted      = out_exh_r;
  assign out_query_host     = out_qh_r;
  assign out_query_dirty    = out_qd_r;
  assign out_host_is_mapped = out_him_r;
  assign out_temp_mask      = out_tm_r;
  assign out_new_alloc_mask = out_cm_r;

endmodule

// ----- sv/lgrc_ctrl.sv -----
// Controller: sequences one request through the datapath steps.
`timescale 1ns / 1ps
module lgrc_ctrl import lgrc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lgrc_sts_t sts,
  output lgrc_cmd_t cmd
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_DISP  = 19'h00002,
    S_HIT   = 19'h00004,
    S_TAKE1 = 19'h00008,
    S_EPICK = 19'h00010,
    S_ERM   = 19'h00020,
    S_RMV   = 19'h00040,
    S_TAKE2 = 19'h00080,
    S_GOT   = 19'h00100,
    S_INS   = 19'h00200,
    S_ISH   = 19'h00400,
    S_DA    = 19'h00800,
    S_DB    = 19'h01000,
    S_ASGN  = 19'h02000,
    S_LCHK  = 19'h04000,
    S_STORE = 19'h08000,
    S_SALL  = 19'h10000,
    S_FLN   = 19'h20000,
    S_RESP  = 19'h40000
  } lgrc_state_t;

  lgrc_state_t state_r, state_nxt, back_r, back_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    back_nxt  = back_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_RESP;
        case (sts.op)
          OP_MAP_READ, OP_MAP_WRITE: state_nxt = sts.g_mapped ? S_HIT : S_TAKE1;
          OP_COPY_TEMP, OP_ALLOC_TEMP: state_nxt = S_TAKE1;
          OP_ASSIGN: state_nxt = S_ASGN;
          OP_SET_DIRTY: cmd.set_dirty_g = sts.g_mapped;
          OP_TOUCH: cmd.list_touch = 1'b1;
          OP_REMOVE: begin
            cmd.set_tgt_g = 1'b1;
            state_nxt     = S_RMV;
          end
          OP_STORE_ONE: begin
            cmd.set_tgt_g = 1'b1;
            state_nxt     = S_STORE;
          end
          OP_STORE_ALL: begin
            cmd.set_tgt_cnt = 1'b1;
            state_nxt       = S_SALL;
          end
          OP_FLUSH: begin
            cmd.set_tgt_cnt = 1'b1;
            back_nxt        = S_FLN;
            state_nxt       = S_DA;
          end
          OP_FREE_HOST: begin
            cmd.rel_from_hr = 1'b1;
            back_nxt        = S_RESP;
            state_nxt       = S_DB;
          end
          OP_CLEAR_CHANGED: cmd.clear_changed = 1'b1;
          default: state_nxt = S_RESP;
        endcase
      end
      S_HIT: begin
        cmd.set_dirty_g  = sts.op == OP_MAP_WRITE;
        cmd.list_touch   = 1'b1;
        cmd.ret_from_map = 1'b1;
        state_nxt        = S_RESP;
      end
      S_TAKE1: begin
        cmd.take  = sts.pool_free;
        state_nxt = sts.pool_free ? S_GOT : S_EPICK;
      end
      S_EPICK: begin
        cmd.set_tgt_victim = !sts.list_empty;
        state_nxt          = sts.list_empty ? S_TAKE2 : S_ERM;
      end
      S_ERM: begin
        cmd.list_remove = 1'b1;
        back_nxt        = S_TAKE2;
        state_nxt       = S_DA;
      end
      S_RMV: begin
        cmd.list_remove = 1'b1;
        back_nxt        = S_RESP;
        state_nxt       = sts.tgt_in_list ? S_DA : S_RESP;
      end
      S_TAKE2: begin
        cmd.take    = sts.pool_free;
        cmd.exh_set = !sts.pool_free;
        state_nxt   = sts.pool_free ? S_GOT : S_RESP;
      end
      S_GOT: begin
        case (sts.op)
          OP_MAP_READ: begin
            if (sts.out_free) begin
              cmd.map_g_h    = 1'b1;
              cmd.emit       = 1'b1;
              cmd.emit_kind  = KIND_LOAD;
              cmd.ret_from_h = 1'b1;
              state_nxt      = S_INS;
            end
          end
          OP_MAP_WRITE: begin
            cmd.map_g_h     = 1'b1;
            cmd.set_dirty_g = 1'b1;
            cmd.ret_from_h  = 1'b1;
            state_nxt       = S_INS;
          end
          OP_COPY_TEMP: begin
            if (sts.out_free) begin
              cmd.emit       = 1'b1;
              cmd.emit_kind  = sts.g_mapped ? KIND_MOVE : KIND_LOAD;
              cmd.ret_from_h = 1'b1;
              state_nxt      = S_RESP;
            end
          end
          default: begin
            cmd.ret_from_h = 1'b1;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_INS: begin
        // A full list drops its oldest guest before the shift.
        cmd.set_tgt_last = sts.last_valid;
        back_nxt         = S_ISH;
        state_nxt        = sts.last_valid ? S_DA : S_ISH;
      end
      S_ISH: begin
        cmd.list_insert = 1'b1;
        state_nxt       = S_RESP;
      end
      S_DA: begin
        if (sts.out_free || !sts.tgt_dirty) begin
          cmd.emit      = sts.tgt_dirty;
          cmd.emit_kind = KIND_STORE;
          cmd.disc_a    = 1'b1;
          state_nxt     = S_DB;
        end
      end
      S_DB: begin
        cmd.release_host = 1'b1;
        state_nxt        = back_r;
      end
      S_ASGN: begin
        cmd.assign_a    = 1'b1;
        cmd.ret_from_hr = 1'b1;
        back_nxt        = S_LCHK;
        state_nxt       = S_DB;
      end
      S_LCHK: begin
        cmd.list_touch = sts.g_in_list;
        state_nxt      = sts.g_in_list ? S_RESP : S_INS;
      end
      S_STORE: begin
        if (sts.out_free || !sts.tgt_dirty) begin
          cmd.emit      = sts.tgt_dirty;
          cmd.emit_kind = KIND_STORE;
          state_nxt     = S_RESP;
        end
      end
      S_SALL: begin
        if (sts.out_free || !sts.tgt_dirty) begin
          cmd.emit      = sts.tgt_dirty;
          cmd.emit_kind = KIND_STORE;
          cmd.cnt_inc   = !sts.cnt_last;
          state_nxt     = sts.cnt_last ? S_RESP : S_SALL;
        end
      end
      S_FLN: begin
        cmd.list_clear = sts.cnt_last;
        cmd.cnt_inc    = !sts.cnt_last;
        state_nxt      = sts.cnt_last ? S_RESP : S_DA;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_RESP;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      back_r  <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      back_r  <= back_nxt;
    end
  end

endmodule

// ----- sv/lru_guest_register_cache_unit.sv -----
// Top level of the guest register cache with recency-ordered replacement.
//
//   channel  direction  handshake          contents
//   in_      input      tvalid / tready    tuser: op, tdata: guest_reg, host_reg
//   out_     output     tvalid / tready    tuser: kind, tlast: last, tdata: fields
//   cfg_     input      wr_en              wr_data: pool_size
//
// One request is handled at a time by a step sequencer; a step that emits an item
// waits while the output side stalls. Each step is one state of the controller.
// The response waits in the output register while the next item is accepted.
// Reset is synchronous and leaves all guests unmapped, the pool empty and
// pool_size at 10.
`timescale 1ns / 1ps
module lru_guest_register_cache_unit import lgrc_pkg::*; #(
  parameter int LRU_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,   // op
  input  logic [7:0]  in_tdata,   // guest_reg, host_reg
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,  // last
  // action_guest, result_host, source_host, exhausted, query_host,
  // query_dirty, host_is_mapped, temp_mask, new_alloc_mask, zero fill
  output logic [55:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  lgrc_cmd_t     cmd;
  lgrc_sts_t     sts;
  logic [1:0]    kind;
  logic [GW-1:0] action_guest;
  logic [HW-1:0] result_host, source_host;
  logic          exhausted, query_dirty, host_is_mapped;
  logic [4:0]    query_host;
  logic [15:0]   temp_mask, new_alloc_mask;

  lgrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lgrc_datapath #(.LRU_SLOTS(LRU_SLOTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_op              (in_tuser),
    .in_guest_reg       (in_tdata[3:0]),
    .in_host_reg        (in_tdata[7:4]),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .cmd                (cmd),
    .sts                (sts),
    .out_tready         (out_tready),
    .out_valid          (out_tvalid),
    .out_kind           (kind),
    .out_action_guest   (action_guest),
    .out_result_host    (result_host),
    .out_source_host    (source_host),
    .out_exhausted      (exhausted),
    .out_query_host     (query_host),
    .out_query_dirty    (query_dirty),
    .out_host_is_mapped (host_is_mapped),
    .out_temp_mask      (temp_mask),
    .out_new_alloc_mask (new_alloc_mask)
  );

  assign out_tuser = kind;
  assign out_tlast = kind == KIND_RESP;
  assign out_tdata = {4'b0000, new_alloc_mask, temp_mask, host_is_mapped, query_dirty,
                      query_host, exhausted, source_host, result_host, action_guest};

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the guest register cache unit.
`timescale 1ns / 1ps
module tb;
  import lgrc_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [55:0] data;
  } cache_item_t;

  // Predictor of the cache state and the items each request produces.
  class cache_scoreboard;
    logic [4:0]  gmap [GUEST_REGS];
    logic        gdirty [GUEST_REGS];
    logic [4:0]  order [8];
    logic [15:0] used;
    logic [15:0] changed;
    logic [4:0]  psize;
    cache_item_t pending [$];
    int          errors;
    int          n_actions;

    function new();
      for (int i = 0; i < GUEST_REGS; i++) begin
        gmap[i] = NO_HOST;
        gdirty[i] = 0;
      end
      for (int i = 0; i < 8; i++) order[i] = NO_GUEST;
      used = 0;
      changed = 0;
      psize = POOL_SIZE_RESET;
      errors = 0;
      n_actions = 0;
    endfunction

    function void push_action(lgrc_kind_t k, int g, int dst, int src);
      cache_item_t it;
      if (n_actions >= MAX_ACTIONS) return;
      it.kind = k;
      it.last = 0;
      it.data = 56'(g[3:0]) | (56'(dst[3:0]) << 4) | (56'(src[3:0]) << 8);
      pending.push_back(it);
      n_actions++;
    endfunction

    function bit is_mapped(int h);
      for (int i = 0; i < GUEST_REGS; i++)
        if (gmap[i] == h) return 1;
      return 0;
    endfunction

    function void release_reg(int h);
      if (h >= HOST_REGS) return;
      if (is_mapped(h)) return;
      used[h] = 1'b0;
    endfunction

    function int bound();
      return (psize > 16) ? 16 : int'(psize);
    endfunction

    function int take_free();
      for (int i = 0; i < bound(); i++)
        if (!used[i]) begin
          used[i] = 1'b1;
          changed[i] = 1'b1;
          return i;
        end
      return int'(NO_HOST);
    endfunction

    function void drop_guest(int g);
      int h;
      h = int'(gmap[g]);
      if (gdirty[g]) push_action(KIND_STORE, g, 0, h);
      gdirty[g] = 0;
      gmap[g] = NO_HOST;
      release_reg(h);
    endfunction

    function void unlist(int g);
      int j;
      bit found;
      j = 0;
      found = 0;
      for (int i = 0; i < 8; i++) begin
        if (order[i] == g) found = 1;
        else begin
          order[j] = order[i];
          j++;
        end
      end
      while (j < 8) begin
        order[j] = NO_GUEST;
        j++;
      end
      if (found) drop_guest(g);
    endfunction

    function bit listed(int g);
      for (int i = 0; i < 8; i++)
        if (order[i] == g) return 1;
      return 0;
    endfunction

    function void promote(int g);
      if (order[0] == g) return;
      for (int i = 1; i < 8; i++)
        if (order[i] == g) begin
          for (int j = i; j > 0; j--) order[j] = order[j-1];
          order[0] = 5'(g);
          return;
        end
    endfunction

    function void push_front(int g);
      if (order[7] != NO_GUEST) drop_guest(int'(order[7]));
      for (int i = 7; i > 0; i--) order[i] = order[i-1];
      order[0] = 5'(g);
    endfunction

    function int grab_host();
      int h;
      h = take_free();
      if (h != NO_HOST) return h;
      for (int i = 7; i >= 0; i--)
        if (order[i] != NO_GUEST) begin
          unlist(int'(order[i]));
          break;
        end
      return take_free();
    endfunction

    // Notes an accepted request and queues the items it produces.
    function void note_request(logic [3:0] op, logic [3:0] g, logic [3:0] hr);
      int h, ret;
      bit exh;
      logic [15:0] tmask;
      cache_item_t it;
      n_actions = 0;
      ret = 0;
      exh = 0;
      case (op)
        OP_MAP_READ, OP_MAP_WRITE: begin
          if (gmap[g] != NO_HOST) begin
            if (op == OP_MAP_WRITE) gdirty[g] = 1;
            promote(int'(g));
            ret = int'(gmap[g]);
          end else begin
            h = grab_host();
            if (h == NO_HOST) exh = 1;
            else begin
              gmap[g] = 5'(h);
              if (op == OP_MAP_READ) push_action(KIND_LOAD, int'(g), h, 0);
              else gdirty[g] = 1;
              push_front(int'(g));
              ret = h;
            end
          end
        end
        OP_COPY_TEMP: begin
          h = grab_host();
          if (h == NO_HOST) exh = 1;
          else begin
            if (gmap[g] != NO_HOST) push_action(KIND_MOVE, 0, h, int'(gmap[g]));
            else push_action(KIND_LOAD, int'(g), h, 0);
            ret = h;
          end
        end
        OP_ASSIGN: begin
          h = int'(gmap[g]);
          gmap[g] = {1'b0, hr};
          gdirty[g] = 1;
          release_reg(h);
          if (listed(int'(g))) promote(int'(g));
          else push_front(int'(g));
          ret = int'(hr);
        end
        OP_SET_DIRTY: if (gmap[g] != NO_HOST) gdirty[g] = 1;
        OP_TOUCH: promote(int'(g));
        OP_REMOVE: unlist(int'(g));
        OP_STORE_ONE: if (gdirty[g]) push_action(KIND_STORE, int'(g), 0, int'(gmap[g]));
        OP_STORE_ALL:
          for (int i = 0; i < GUEST_REGS; i++)
            if (gdirty[i]) push_action(KIND_STORE, i, 0, int'(gmap[i]));
        OP_FLUSH: begin
          for (int i = 0; i < GUEST_REGS; i++) drop_guest(i);
          for (int i = 0; i < 8; i++) order[i] = NO_GUEST;
        end
        OP_ALLOC_TEMP: begin
          h = grab_host();
          if (h == NO_HOST) exh = 1;
          else ret = h;
        end
        OP_FREE_HOST: release_reg(int'(hr));
        OP_CLEAR_CHANGED: changed = 0;
        default: ;
      endcase
      tmask = 0;
      for (int i = 0; i < bound(); i++)
        if (used[i] && !is_mapped(i)) tmask[i] = 1'b1;
      it.kind = KIND_RESP;
      it.last = 1;
      it.data = {4'b0, changed, tmask, is_mapped(int'(hr)), gdirty[g], gmap[g], exh,
                 4'd0, 4'(ret), 4'd0};
      pending.push_back(it);
    endfunction

    function void check_item(cache_item_t got);
      cache_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected item: %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected kind %0d last %0d data %h, got kind %0d last %0d data %h",
                   want.kind, want.last, want.data, got.kind, got.last, got.data);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [3:0]  in_tuser;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic [55:0] out_tdata;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;

  cache_scoreboard sb;
  int send_idle;
  int recv_stall;

  lru_guest_register_cache_unit uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls and checking.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_item({out_tuser, out_tlast, out_tdata});
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // The valid line stays up after an accept; the next call or a drain settles it.
  task automatic send_request(lgrc_op_t op, int g, int hr);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {4'(hr), 4'(g)};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, 4'(g), 4'(hr));
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_pool(int n);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= 5'(n);
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.psize = 5'(n);
  endtask

  // Mostly map traffic on all sixteen guests so the recency list fills and evicts.
  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 55) send_request(lgrc_op_t'($urandom_range(1)), $urandom_range(15),
                             $urandom_range(15));
    else send_request(lgrc_op_t'($urandom_range(15)), $urandom_range(15),
                      $urandom_range(15));
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = 0;
    out_tready = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: every operation, field extremes, exhaustion and eviction.
    send_request(OP_STATUS, 0, 0);
    send_request(OP_MAP_READ, 0, 0);
    send_request(OP_MAP_WRITE, 15, 15);
    send_request(OP_COPY_TEMP, 0, 0);
    send_request(OP_COPY_TEMP, 3, 0);
    send_request(OP_ASSIGN, 8, 15);
    send_request(OP_SET_DIRTY, 0, 0);
    send_request(OP_SET_DIRTY, 5, 0);
    send_request(OP_TOUCH, 15, 0);
    send_request(OP_TOUCH, 7, 0);
    send_request(OP_STORE_ONE, 15, 0);
    send_request(OP_STORE_ALL, 0, 0);
    send_request(OP_ALLOC_TEMP, 0, 1);
    send_request(OP_FREE_HOST, 0, 0);
    send_request(OP_FREE_HOST, 0, 3);
    send_request(OP_REMOVE, 0, 0);
    send_request(OP_CLEAR_CHANGED, 0, 0);
    send_request(lgrc_op_t'(4'd14), 2, 2);
    send_request(lgrc_op_t'(4'd15), 15, 15);
    send_request(OP_FLUSH, 0, 0);
    set_pool(1);
    send_request(OP_MAP_WRITE, 1, 0);
    send_request(OP_ALLOC_TEMP, 2, 0);
    send_request(OP_ALLOC_TEMP, 2, 0);
    set_pool(0);
    send_request(OP_MAP_READ, 4, 0);
    send_request(OP_FLUSH, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_pool(16);
        1: set_pool(31);
        2: set_pool(4);
        3: set_pool(10);
        default: set_pool($urandom_range(1, 16));
      endcase
      send_idle = (ph == 1 || ph == 4) ? 67 : (ph == 3 ? 36 : 0);
      recv_stall = (ph == 2 || ph == 4) ? 67 : (ph == 3 ? 36 : 0);
      for (int i = 0; i < 19; i++) random_request();
      if (ph == 2) drain();
    end

    drain();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- lru_guest_register_cache_unit.f -----
sv/lgrc_pkg.sv
sv/lgrc_datapath.sv
sv/lgrc_ctrl.sv
sv/lru_guest_register_cache_unit.sv
sim/tb.sv
